// File: sv/lwbsc_pkg.sv
package lwbsc_pkg;

    localparam int SLOTS   = 16;
    localparam int SW      = $clog2(SLOTS);
    localparam int MAX_OUT = 16;
    localparam int CW      = $clog2(MAX_OUT + 1);
    localparam int ADDR_W  = 28;
    localparam int QDEPTH  = 2;
    localparam int QW      = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCW     = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        FUNC_READ  = 2'd0,
        FUNC_WRITE = 2'd1,
        FUNC_FLUSH = 2'd2,
        FUNC_NONE  = 2'd3
    } t_func;

    typedef struct packed {
        t_func              func;
        logic [ADDR_W-1:0]  addr;
    } t_req;

    typedef struct packed {
        logic [3:0]         slot;
        logic               hit;
        logic               wb;
        logic [ADDR_W-1:0]  wba;
        logic               fill;
        logic               last;
        logic [31:0]        rh;
        logic [31:0]        rm;
    } t_res;

endpackage

// File: sv/lru_write_back_sector_cache.sv
// Channel   Dir  Handshake                       Payload
// s_axis    in   s_axis_tvalid / s_axis_tready   tdata: sector_addr; tuser: func
// m_axis    out  m_axis_tvalid / m_axis_tready   tdata: result fields; tlast: last
//
// Read or write: the scan compares one slot per cycle over the tag/time arrays, then
// commits the victim when the result is taken.
// Flush: one slot per cycle up to the last dirty slot (all slots when none is dirty) or
// the MAX_OUT-th result; a dirty slot waits while the sink holds a result.
// A two-item request queue lets items arrive while a request is in the scan.
// Synchronous active-low reset clears valid, dirty, times, use clock and counters.
// The result register takes a new item whenever it is empty or being drained.
module lru_write_back_sector_cache (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            s_axis_tvalid,
    output logic            s_axis_tready,
    input  logic [31:0]     s_axis_tdata,   // [27:0] sector_addr, zero fill above
    input  logic [1:0]      s_axis_tuser,   // [1:0] func
    output logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    // [3:0] slot, [4] hit, [5] writeback_needed, [33:6] writeback_addr,
    // [34] fill_needed, [66:35] read_hits, [98:67] read_misses, zero fill above
    output logic [103:0]    m_axis_tdata,
    output logic            m_axis_tlast
);

    lwbsc_pkg::t_req    in_req;
    lwbsc_pkg::t_req    q_req;
    logic               q_valid;
    logic               q_ready;
    lwbsc_pkg::t_res    res;
    logic               res_valid;
    logic               res_ready;
    logic               r_out_v;
    lwbsc_pkg::t_res    r_out;

    assign in_req.func = lwbsc_pkg::t_func'(s_axis_tuser);
    assign in_req.addr = s_axis_tdata[lwbsc_pkg::ADDR_W-1:0];

    lwbsc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_req       (in_req),
        .o_req_valid (q_valid),
        .i_req_ready (q_ready),
        .o_req       (q_req)
    );

    lwbsc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (q_valid),
        .o_req_ready (q_ready),
        .i_req       (q_req),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    assign res_ready = !r_out_v || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (res_ready) begin
            r_out_v <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tlast  = r_out.last;
    assign m_axis_tdata  = {5'b0, r_out.rm, r_out.rh, r_out.fill, r_out.wba,
                            r_out.wb, r_out.hit, r_out.slot};

endmodule

// File: sv/lwbsc_front.sv
module lwbsc_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  lwbsc_pkg::t_req     i_req,
    output logic                o_req_valid,
    input  logic                i_req_ready,
    output lwbsc_pkg::t_req     o_req
);

    lwbsc_pkg::t_req            r_q [lwbsc_pkg::QDEPTH];
    logic [lwbsc_pkg::QW-1:0]   r_wp;
    logic [lwbsc_pkg::QW-1:0]   r_rp;
    logic [lwbsc_pkg::QCW-1:0]  r_cnt;
    logic                       push;
    logic                       pop;

    function automatic logic [lwbsc_pkg::QW-1:0] f_inc(input logic [lwbsc_pkg::QW-1:0] p);
        f_inc = (p == lwbsc_pkg::QW'(lwbsc_pkg::QDEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_ready     = (r_cnt != lwbsc_pkg::QCW'(lwbsc_pkg::QDEPTH));
    // drop unused request kinds here
    assign push        = i_valid && o_ready && (i_req.func != lwbsc_pkg::FUNC_NONE);
    assign o_req_valid = (r_cnt != '0);
    assign pop         = o_req_valid && i_req_ready;
    assign o_req       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= f_inc(r_wp);
            end
            if (pop) begin
                r_rp <= f_inc(r_rp);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= i_req;
        end
    end

endmodule

// File: sv/lwbsc_back.sv
module lwbsc_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_req_valid,
    output logic                o_req_ready,
    input  lwbsc_pkg::t_req     i_req,
    output logic                o_res_valid,
    input  logic                i_res_ready,
    output lwbsc_pkg::t_res     o_res
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_FINISH = 4'b0100,
        S_FLUSH  = 4'b1000
    } t_state;

    localparam logic [lwbsc_pkg::SW-1:0] LAST_IDX = lwbsc_pkg::SW'(lwbsc_pkg::SLOTS - 1);

    t_state                         r_state;
    logic [lwbsc_pkg::SW-1:0]       r_idx;
    lwbsc_pkg::t_func               r_func;
    logic [lwbsc_pkg::ADDR_W-1:0]   r_addr;
    logic [31:0]                    r_clock;
    logic [31:0]                    r_hits;
    logic [31:0]                    r_miss;
    logic [lwbsc_pkg::SLOTS-1:0]    r_valid;
    logic [lwbsc_pkg::SLOTS-1:0]    r_dirty;
    logic [31:0]                    r_time [lwbsc_pkg::SLOTS];
    logic [lwbsc_pkg::ADDR_W-1:0]   r_tag  [lwbsc_pkg::SLOTS];
    logic                           r_found;
    logic [lwbsc_pkg::SW-1:0]       r_found_idx;
    logic                           r_inv;
    logic [lwbsc_pkg::SW-1:0]       r_inv_idx;
    logic [lwbsc_pkg::SW-1:0]       r_best_idx;
    logic [31:0]                    r_best_time;
    logic [lwbsc_pkg::ADDR_W-1:0]   r_best_tag;
    logic                           r_best_valid;
    logic                           r_best_dirty;
    logic [lwbsc_pkg::CW-1:0]       r_cnt;

    logic [lwbsc_pkg::SLOTS-1:0]    vd;
    logic                           cur_dirty;
    logic                           more_dirty;
    logic                           flush_last;
    logic [lwbsc_pkg::SW-1:0]       v_idx;
    logic                           v_wb;
    logic                           is_read;
    logic [31:0]                    n_hits;
    logic [31:0]                    n_miss;

    assign vd         = r_valid & r_dirty;
    assign cur_dirty  = vd[r_idx];
    assign more_dirty = ((vd >> r_idx) >> 1) != '0;
    assign flush_last = !more_dirty || (r_cnt == lwbsc_pkg::CW'(lwbsc_pkg::MAX_OUT - 1));
    assign is_read    = (r_func == lwbsc_pkg::FUNC_READ);
    assign v_idx      = r_found ? r_found_idx : (r_inv ? r_inv_idx : r_best_idx);
    assign v_wb       = !r_found && !r_inv && r_best_valid && r_best_dirty;
    assign n_hits     = r_hits + 32'(is_read && r_found);
    assign n_miss     = r_miss + 32'(is_read && !r_found);

    assign o_req_ready = (r_state == S_IDLE);

    always_comb begin
        o_res_valid = 1'b0;
        o_res       = '0;
        o_res.rh    = r_hits;
        o_res.rm    = r_miss;
        case (r_state)
            S_FINISH: begin
                o_res_valid = 1'b1;
                o_res.slot  = 4'(v_idx);
                o_res.hit   = r_found;
                o_res.wb    = v_wb;
                o_res.wba   = v_wb ? r_best_tag : '0;
                o_res.fill  = !r_found && is_read;
                o_res.last  = 1'b1;
                o_res.rh    = n_hits;
                o_res.rm    = n_miss;
            end
            S_FLUSH: begin
                o_res_valid = cur_dirty;
                o_res.slot  = 4'(r_idx);
                o_res.wb    = 1'b1;
                o_res.wba   = r_tag[r_idx];
                o_res.last  = flush_last;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_clock <= '0;
            r_hits  <= '0;
            r_miss  <= '0;
            r_valid <= '0;
            r_dirty <= '0;
            r_cnt   <= '0;
            r_found <= 1'b0;
            r_inv   <= 1'b0;
            for (int i = 0; i < lwbsc_pkg::SLOTS; i++) begin
                r_time[i] <= '0;
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_req_valid) begin
                        r_func  <= i_req.func;
                        r_addr  <= i_req.addr;
                        r_idx   <= '0;
                        r_cnt   <= '0;
                        r_found <= 1'b0;
                        r_inv   <= 1'b0;
                        if (i_req.func == lwbsc_pkg::FUNC_FLUSH) begin
                            r_state <= S_FLUSH;
                        end else begin
                            r_clock <= r_clock + 1'b1;
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    // one slot per cycle: match, first empty above slot 0, least recent
                    if (r_valid[r_idx] && (r_tag[r_idx] == r_addr) && !r_found) begin
                        r_found     <= 1'b1;
                        r_found_idx <= r_idx;
                    end
                    if (!r_valid[r_idx] && (r_idx != '0) && !r_inv) begin
                        r_inv     <= 1'b1;
                        r_inv_idx <= r_idx;
                    end
                    if ((r_idx == '0) || (r_time[r_idx] < r_best_time)) begin
                        r_best_idx   <= r_idx;
                        r_best_time  <= r_time[r_idx];
                        r_best_tag   <= r_tag[r_idx];
                        r_best_valid <= r_valid[r_idx];
                        r_best_dirty <= r_dirty[r_idx];
                    end
                    if (r_idx == LAST_IDX) begin
                        r_state <= S_FINISH;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_FINISH: begin
                    if (i_res_ready) begin
                        r_hits          <= n_hits;
                        r_miss          <= n_miss;
                        r_time[v_idx]   <= r_clock;
                        r_valid[v_idx]  <= 1'b1;
                        if (r_found) begin
                            if (!is_read) begin
                                r_dirty[v_idx] <= 1'b1;
                            end
                        end else begin
                            r_dirty[v_idx] <= !is_read;
                        end
                        r_state <= S_IDLE;
                    end
                end
                S_FLUSH: begin
                    if (cur_dirty) begin
                        if (i_res_ready) begin
                            r_dirty[r_idx] <= 1'b0;
                            r_cnt          <= r_cnt + 1'b1;
                            if (flush_last || (r_idx == LAST_IDX)) begin
                                r_state <= S_IDLE;
                            end else begin
                                r_idx <= r_idx + 1'b1;
                            end
                        end
                    end else if (r_idx == LAST_IDX) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_FINISH) && i_res_ready && !r_found) begin
            r_tag[v_idx] <= r_addr;
        end
    end

    a_res_only_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (r_state == S_FINISH || r_state == S_FLUSH))
        else $error("result offered outside finish or flush");

    a_hit_no_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.hit) |-> (!o_res.wb && !o_res.fill))
        else $error("hit result asks for disk traffic");

    a_flush_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= lwbsc_pkg::CW'(lwbsc_pkg::MAX_OUT))
        else $error("flush result count overrun");

    a_flush_cleans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FLUSH && cur_dirty && i_res_ready) |=> !r_dirty[$past(r_idx)])
        else $error("flushed slot still dirty");

endmodule

// File: tb/tb_lru_write_back_sector_cache.sv
module tb_lru_write_back_sector_cache;
    import lwbsc_pkg::*;

    typedef struct {
        logic [3:0]        slot;
        logic              hit;
        logic              wb;
        logic [ADDR_W-1:0] wba;
        logic              fill;
        logic              last;
        logic [31:0]       rh;
        logic [31:0]       rm;
    } t_outcome;

    class cache_scoreboard;
        logic [ADDR_W-1:0] tag_q[SLOTS];
        bit                valid_q[SLOTS];
        bit                dirty_q[SLOTS];
        logic [31:0]       time_q[SLOTS];
        logic [31:0]       clock_q;
        logic [31:0]       hits_q;
        logic [31:0]       misses_q;
        t_outcome          pending[$];
        int                mismatches;

        function void clear();
            for (int i = 0; i < SLOTS; i++) begin
                tag_q[i] = '0;
                valid_q[i] = 0;
                dirty_q[i] = 0;
                time_q[i] = '0;
            end
            clock_q = '0;
            hits_q = '0;
            misses_q = '0;
            mismatches = 0;
        endfunction

        function int choose_victim();
            int best;
            best = 0;
            for (int i = 1; i < SLOTS; i++)
                if (!valid_q[i]) return i;
            for (int i = 1; i < SLOTS; i++)
                if (time_q[i] < time_q[best]) best = i;
            return best;
        endfunction

        function void note_request(t_func f, logic [ADDR_W-1:0] a);
            t_outcome o;
            int found;
            int v;
            int n;
            found = -1;
            n = 0;
            o.rh = '0;
            o.rm = '0;
            if (f == FUNC_FLUSH) begin
                for (int i = 0; i < SLOTS && n < MAX_OUT; i++) begin
                    if (valid_q[i] && dirty_q[i]) begin
                        dirty_q[i] = 0;
                        o.slot = i[3:0];
                        o.hit = 0;
                        o.wb = 1;
                        o.wba = tag_q[i];
                        o.fill = 0;
                        o.last = 0;
                        o.rh = hits_q;
                        o.rm = misses_q;
                        pending.push_back(o);
                        n++;
                    end
                end
                if (n > 0) pending[$].last = 1;
                return;
            end
            if (f == FUNC_NONE) return;
            clock_q++;
            for (int i = 0; i < SLOTS; i++)
                if (found < 0 && valid_q[i] && tag_q[i] == a) found = i;
            o.last = 1;
            o.wb = 0;
            o.wba = '0;
            o.fill = 0;
            if (found >= 0) begin
                time_q[found] = clock_q;
                if (f == FUNC_WRITE) dirty_q[found] = 1;
                else hits_q++;
                o.slot = found[3:0];
                o.hit = 1;
            end else begin
                v = choose_victim();
                if (valid_q[v] && dirty_q[v]) begin
                    o.wb = 1;
                    o.wba = tag_q[v];
                end
                tag_q[v] = a;
                valid_q[v] = 1;
                time_q[v] = clock_q;
                dirty_q[v] = (f == FUNC_WRITE);
                if (f == FUNC_READ) begin
                    misses_q++;
                    o.fill = 1;
                end
                o.slot = v[3:0];
                o.hit = 0;
            end
            o.rh = hits_q;
            o.rm = misses_q;
            pending.push_back(o);
        endfunction

        function void check_result(logic [103:0] d, logic l);
            t_outcome e;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h last %b", d, l);
                return;
            end
            e = pending.pop_front();
            if (d[3:0] !== e.slot || d[4] !== e.hit || d[5] !== e.wb
                || d[33:6] !== e.wba || d[34] !== e.fill || l !== e.last
                || d[66:35] !== e.rh || d[98:67] !== e.rm || d[103:99] !== '0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp slot %0d hit %b wb %b wba %h fill %b last %b rh %0d rm %0d; got slot %0d hit %b wb %b wba %h fill %b last %b rh %0d rm %0d",
                        e.slot, e.hit, e.wb, e.wba, e.fill, e.last, e.rh, e.rm,
                        d[3:0], d[4], d[5], d[33:6], d[34], l, d[66:35], d[98:67]);
            end
        endfunction
    endclass

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [31:0]  s_axis_tdata;   // [27:0] sector_addr
    logic [1:0]   s_axis_tuser;   // [1:0] func
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [103:0] m_axis_tdata;   // slot, hit, wb, wb addr, fill, read hits, read misses
    logic         m_axis_tlast;

    cache_scoreboard sb;
    bit              sink_done;
    logic [ADDR_W-1:0] addr_pool[8];

    lru_write_back_sector_cache u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #20000000;
        $display("lru_write_back_sector_cache regression: fail");
        $finish;
    end

    // drop valid for a random gap, then hold the request until accepted
    task automatic send_request(t_func f, logic [ADDR_W-1:0] a);
        int gap;
        gap = (($urandom % 4) == 0) ? 0 : $urandom_range(0, 6);
        @(negedge i_clk);
        if (gap != 0) begin
            s_axis_tvalid <= 0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tuser <= f;
        s_axis_tdata <= {4'b0, a};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request(f, a);
    endtask

    function automatic logic [ADDR_W-1:0] pick_addr();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7) return addr_pool[$urandom_range(0, 7)] + ADDR_W'($urandom_range(0, 15));
        if (r == 7) return '1;
        if (r == 8) return '0;
        return ADDR_W'($urandom);
    endfunction

    initial begin
        int stall;
        sink_done = 0;
        m_axis_tready = 0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            @(negedge i_clk);
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            if (stall != 0) begin
                m_axis_tready <= 0;
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready <= 1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            sb.check_result(m_axis_tdata, m_axis_tlast);
        end
    end

    initial begin
        int r;
        int wait_cycles;
        t_func f;
        sb = new();
        sb.clear();
        i_rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        s_axis_tuser = FUNC_READ;
        for (int i = 0; i < 8; i++) addr_pool[i] = ADDR_W'($urandom);
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // directed: empty flush, idle kind, extremes, fill all slots, evictions
        send_request(FUNC_FLUSH, '0);
        send_request(FUNC_NONE, '1);
        send_request(FUNC_READ, '0);
        send_request(FUNC_WRITE, '1);
        send_request(FUNC_READ, '1);
        send_request(FUNC_WRITE, '0);
        for (int i = 0; i < 16; i++)
            send_request((i % 2) ? FUNC_WRITE : FUNC_READ, ADDR_W'(28'h5555555 ^ i));
        send_request(FUNC_WRITE, 28'hAAAAAAA);
        send_request(FUNC_FLUSH, 28'h1234567);
        send_request(FUNC_FLUSH, '0);

        for (int n = 0; n < 330; n++) begin
            r = $urandom_range(0, 19);
            if (r < 9) f = FUNC_READ;
            else if (r < 17) f = FUNC_WRITE;
            else if (r < 19) f = FUNC_FLUSH;
            else f = FUNC_NONE;
            send_request(f, pick_addr());
            if (n % 60 == 59)
                for (int i = 0; i < 8; i++) addr_pool[i] = ADDR_W'($urandom);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 0;

        wait_cycles = 0;
        while (sb.pending.size() != 0 && wait_cycles < 100000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (100) @(posedge i_clk);
        if (sb.pending.size() == 0 && sb.mismatches == 0)
            $display("lru_write_back_sector_cache regression: pass");
        else
            $display("lru_write_back_sector_cache regression: fail");
        $finish;
    end
endmodule

// File: filelist.f
sv/lwbsc_pkg.sv
sv/lwbsc_front.sv
sv/lwbsc_back.sv
sv/lru_write_back_sector_cache.sv
tb/tb_lru_write_back_sector_cache.sv
